[design/fdcrc_pkg.sv]
// Package for the framed serial deframer: frame size limits, header byte and CRC constants.
// Has no dependencies. The deframer top level imports it.
`default_nettype none

package fdcrc_pkg;

  localparam int unsigned MAX_FRAME = 32;
  localparam int unsigned MIN_FRAME = 7;
  localparam int unsigned ADDR_W    = $clog2(MAX_FRAME);
  localparam int unsigned LEN_W     = 6;

  localparam logic [7:0]  HDR_BYTE  = 8'hAA;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  localparam logic [7:0]       MAX_LEN_BYTE = 8'(MAX_FRAME);
  localparam logic [7:0]       MIN_LEN_BYTE = 8'(MIN_FRAME);
  localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(MIN_FRAME);
  localparam logic [LEN_W-1:0] TYPE_POS     = LEN_W'(3);
  localparam logic [LEN_W-1:0] SEQ_POS      = LEN_W'(4);
  localparam logic [LEN_W-1:0] DATA_POS     = LEN_W'(5);

endpackage

`default_nettype wire

[design/frame_deframer_crc16_ccitt.sv]
// Serial frame deframer with CRC-16/CCITT check (poly 0x1021, init 0xFFFF).
// Depends on fdcrc_pkg and fdcrc_ram (frame byte store).
//
// Input channel: one received byte per beat on rx_byte_i (in_valid_i / in_stall_o).
// The block hunts for two 0xAA bytes, takes a length byte counting the whole frame,
// then type, sequence, payload and two CRC bytes.
// Output channel: one beat per payload byte of a frame whose CRC residue is zero,
// or one beat with has_data_o low for an empty payload (out_valid_o / out_stall_i).
// Bad length or bad CRC frames produce no beat and hunting restarts.
// Input pacing: a byte that is stored in the frame holds off the next byte while
// the bit-serial CRC unit (one bit per cycle) shifts it in; a discarded byte does not.
// After the last byte of a frame the CRC residue is checked, then each payload beat
// passes through RAM read, load and present states; an empty-payload beat is presented
// right after the check. A presented beat is held while out_stall_i is high.
// in_stall_o stays high from the end of a frame until the CRC check fails or the
// last result is taken. A stalled result holds its values. Reset puts the block
// in the hunting state with the CRC at 0xFFFF; the frame store is not cleared.
`default_nettype none

module frame_deframer_crc16_ccitt
  import fdcrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       frame_type_o,
  output logic [7:0]       sequence_number_o,
  output logic [5:0]       frame_length_o,
  output logic [15:0]      received_crc_o,
  output logic             has_data_o,
  output logic [4:0]       data_index_o,
  output logic [7:0]       data_byte_o,
  output logic             last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_CHECK,
    S_RD,
    S_LOAD,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_LEN,
    PH_BODY
  } phase_e;

  state_e             state_q;
  phase_e             phase_q;
  logic [LEN_W-1:0]   cnt_q;
  logic [LEN_W-1:0]   exp_q;
  logic [15:0]        crc_q;
  logic [7:0]         sh_q;
  logic [2:0]         bit_q;
  logic               end_q;
  logic [7:0]         type_q;
  logic [7:0]         seq_q;
  logic [15:0]        crcf_q;
  logic [LEN_W-1:0]   k_q;
  logic               has_data_q;
  logic [7:0]         byte_q;
  logic               last_q;

  logic               accept;
  logic               store;
  logic               is_hdr;
  logic               len_ok;
  logic [15:0]        crc_src;
  logic               bit_in;
  logic [15:0]        crc_d;
  logic [LEN_W-1:0]   cnt_inc;
  logic [LEN_W-1:0]   plen;
  logic [LEN_W-1:0]   rd_pos;
  logic [7:0]         ram_rdata;

  assign accept  = in_valid_i && !in_stall_o;
  assign is_hdr  = (rx_byte_i == HDR_BYTE);
  assign len_ok  = (rx_byte_i <= MAX_LEN_BYTE) && (rx_byte_i >= MIN_LEN_BYTE);
  assign cnt_inc = cnt_q + LEN_W'(1);
  assign plen    = exp_q - MIN_LEN;
  assign rd_pos  = DATA_POS + k_q;

  always_comb begin
    case (phase_q)
      PH_HUNT1: store = is_hdr;
      PH_HUNT2: store = is_hdr;
      PH_LEN:   store = len_ok;
      PH_BODY:  store = 1'b1;
      default:  store = 1'b0;
    endcase
  end

  // shared bit-serial CRC step
  always_comb begin
    crc_src = (state_q == S_IDLE && phase_q == PH_HUNT1) ? CRC_INIT : crc_q;
    bit_in  = (state_q == S_IDLE) ? rx_byte_i[7] : sh_q[7];
    crc_d   = {crc_src[14:0], 1'b0} ^ ((crc_src[15] ^ bit_in) ? CRC_POLY : 16'h0000);
  end

  fdcrc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && store),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (state_q == S_RD),
    .raddr_i (rd_pos[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_HUNT1;
      cnt_q      <= '0;
      exp_q      <= '0;
      crc_q      <= CRC_INIT;
      sh_q       <= '0;
      bit_q      <= '0;
      end_q      <= 1'b0;
      type_q     <= '0;
      seq_q      <= '0;
      crcf_q     <= '0;
      k_q        <= '0;
      has_data_q <= 1'b0;
      byte_q     <= '0;
      last_q     <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (store) begin
              crc_q   <= crc_d;
              sh_q    <= {rx_byte_i[6:0], 1'b0};
              bit_q   <= 3'd1;
              cnt_q   <= cnt_inc;
              end_q   <= (phase_q == PH_BODY) && (cnt_inc == exp_q);
              state_q <= S_CRC;
              case (phase_q)
                PH_HUNT1: phase_q <= PH_HUNT2;
                PH_HUNT2: phase_q <= PH_LEN;
                PH_LEN: begin
                  phase_q <= PH_BODY;
                  exp_q   <= rx_byte_i[LEN_W-1:0];
                end
                default: begin
                  if (cnt_q == TYPE_POS) begin
                    type_q <= rx_byte_i;
                  end
                  if (cnt_q == SEQ_POS) begin
                    seq_q <= rx_byte_i;
                  end
                  crcf_q <= {crcf_q[7:0], rx_byte_i};
                end
              endcase
            end else if (phase_q != PH_HUNT1) begin
              phase_q <= PH_HUNT1;
              cnt_q   <= '0;
              exp_q   <= '0;
              crc_q   <= CRC_INIT;
            end
          end
        end
        S_CRC: begin
          crc_q <= crc_d;
          sh_q  <= {sh_q[6:0], 1'b0};
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            state_q <= end_q ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          k_q <= '0;
          if (crc_q != 16'h0000) begin
            state_q <= S_IDLE;
            phase_q <= PH_HUNT1;
            cnt_q   <= '0;
            exp_q   <= '0;
            crc_q   <= CRC_INIT;
          end else if (plen == '0) begin
            has_data_q <= 1'b0;
            byte_q     <= 8'h00;
            last_q     <= 1'b1;
            state_q    <= S_OUT;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          has_data_q <= 1'b1;
          byte_q     <= ram_rdata;
          last_q     <= (k_q + LEN_W'(1)) == plen;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            if (last_q) begin
              state_q <= S_IDLE;
              phase_q <= PH_HUNT1;
              cnt_q   <= '0;
              exp_q   <= '0;
              crc_q   <= CRC_INIT;
            end else begin
              k_q     <= k_q + LEN_W'(1);
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (state_q == S_OUT);
  assign frame_type_o      = type_q;
  assign sequence_number_o = seq_q;
  assign frame_length_o    = exp_q;
  assign received_crc_o    = crcf_q;
  assign has_data_o        = has_data_q;
  assign data_index_o      = has_data_q ? k_q[4:0] : 5'd0;
  assign data_byte_o       = byte_q;
  assign last_o            = last_q;

endmodule

`default_nettype wire

[design/fdcrc_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// Has no dependencies. Holds the bytes of the frame being received.
`default_nettype none

module fdcrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[tb/deframer_checker.sv]
// Checker for the framed serial deframer: predicts result beats from accepted rx bytes
// and compares every accepted result beat field by field. Depends on fdcrc_pkg.
module deframer_checker
  import fdcrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  frame_type_i,
  input  logic [7:0]  sequence_number_i,
  input  logic [5:0]  frame_length_i,
  input  logic [15:0] received_crc_i,
  input  logic        has_data_i,
  input  logic [4:0]  data_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, TAKE_LENGTH, COLLECT} hunt_phase_e;

  typedef struct packed {
    logic [7:0]  ftype;
    logic [7:0]  seq;
    logic [5:0]  len;
    logic [15:0] crc;
    logic        has_data;
    logic [4:0]  idx;
    logic [7:0]  data;
    logic        last;
  } payload_beat_t;

  hunt_phase_e   phase = HUNT_FIRST;
  logic [7:0]    frame_store [0:63];
  logic [5:0]    byte_count = '0;
  logic [5:0]    want_length = '0;
  logic [15:0]   crc_reg = CRC_INIT;
  payload_beat_t queued_payload_beats [$];
  int            mismatches = 0;

  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc_in,
                                                 input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  task automatic restart_hunt();
    phase       = HUNT_FIRST;
    byte_count  = '0;
    want_length = '0;
    crc_reg     = CRC_INIT;
  endtask

  task automatic store_byte(input logic [7:0] b);
    frame_store[byte_count] = b;
    byte_count = byte_count + 6'd1;
    crc_reg = crc_ccitt_byte(crc_reg, b);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    payload_beat_t beat;
    int            plen;
    case (phase)
      HUNT_FIRST: begin
        if (b == HDR_BYTE) begin
          crc_reg    = CRC_INIT;
          byte_count = '0;
          store_byte(b);
          phase = HUNT_SECOND;
        end
      end
      HUNT_SECOND: begin
        if (b == HDR_BYTE) begin
          store_byte(b);
          phase = TAKE_LENGTH;
        end else begin
          restart_hunt();
        end
      end
      TAKE_LENGTH: begin
        if (b > MAX_LEN_BYTE || b < MIN_LEN_BYTE) begin
          restart_hunt();
        end else begin
          want_length = b[5:0];
          store_byte(b);
          phase = COLLECT;
        end
      end
      default: begin
        store_byte(b);
        if (byte_count >= want_length) begin
          if (crc_reg == 16'h0000) begin
            beat.ftype = frame_store[TYPE_POS];
            beat.seq   = frame_store[SEQ_POS];
            beat.len   = want_length;
            beat.crc   = {frame_store[want_length - 6'd2], frame_store[want_length - 6'd1]};
            plen = want_length - MIN_LEN;
            if (plen == 0) begin
              beat.has_data = 1'b0;
              beat.idx      = '0;
              beat.data     = '0;
              beat.last     = 1'b1;
              queued_payload_beats.push_back(beat);
            end else begin
              for (int k = 0; k < plen; k++) begin
                beat.has_data = 1'b1;
                beat.idx      = 5'(k);
                beat.data     = frame_store[DATA_POS + 6'(k)];
                beat.last     = (k == plen - 1);
                queued_payload_beats.push_back(beat);
              end
            end
          end
          restart_hunt();
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: deframer result mismatch, %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_beat();
    payload_beat_t got, want;
    got = {frame_type_i, sequence_number_i, frame_length_i, received_crc_i,
           has_data_i, data_index_i, data_byte_i, last_i};
    if (queued_payload_beats.size() == 0) begin
      report_mismatch($sformatf("beat with no frame pending: type %02h seq %02h index %0d",
                                got.ftype, got.seq, got.idx));
      return;
    end
    want = queued_payload_beats.pop_front();
    compare_field("frame_type", 16'(got.ftype), 16'(want.ftype));
    compare_field("sequence_number", 16'(got.seq), 16'(want.seq));
    compare_field("frame_length", 16'(got.len), 16'(want.len));
    compare_field("received_crc", got.crc, want.crc);
    compare_field("has_data", 16'(got.has_data), 16'(want.has_data));
    compare_field("data_index", 16'(got.idx), 16'(want.idx));
    compare_field("data_byte", 16'(got.data), 16'(want.data));
    compare_field("last", 16'(got.last), 16'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_hunt();
      queued_payload_beats.delete();
    end else begin
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
      if (out_valid_i && !out_stall_i) check_beat();
    end
    pending_o    <= queued_payload_beats.size();
    fail_count_o <= mismatches;
  end

endmodule

[tb/tb_frame_deframer_crc16_ccitt.sv]
// Top of the deframer testbench: clock, reset, rx byte stimulus and receiver stalls.
// Depends on fdcrc_pkg, frame_deframer_crc16_ccitt and deframer_checker.
module tb_frame_deframer_crc16_ccitt
  import fdcrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_BYTES    = 45;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  frame_type;
  logic [7:0]  sequence_number;
  logic [5:0]  frame_length;
  logic [15:0] received_crc;
  logic        has_data;
  logic [4:0]  data_index;
  logic [7:0]  data_byte;
  logic        last;

  int pending_beats;
  int mismatch_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int frame_bytes_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_ack = 1'b0;
  int idle_tbl [4] = '{0, 63, 0, 22};
  int stall_tbl [4] = '{0, 0, 63, 22};

  frame_deframer_crc16_ccitt dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .frame_type_o      (frame_type),
    .sequence_number_o (sequence_number),
    .frame_length_o    (frame_length),
    .received_crc_o    (received_crc),
    .has_data_o        (has_data),
    .data_index_o      (data_index),
    .data_byte_o       (data_byte),
    .last_o            (last)
  );

  deframer_checker chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .frame_type_i      (frame_type),
    .sequence_number_i (sequence_number),
    .frame_length_i    (frame_length),
    .received_crc_i    (received_crc),
    .has_data_i        (has_data),
    .data_index_i      (data_index),
    .data_byte_i       (data_byte),
    .last_i            (last),
    .fail_count_o      (mismatch_count),
    .pending_o         (pending_beats)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or a long counted hold-off when requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_ack) begin
      out_stall <= 1'b1;
      hold_ack  <= hold_go;
      hold_left <= HOLD_CYCLES - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // keep of 0 or over the frame length sends it whole, else its first keep bytes
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] seq, input int plen,
                            input bit corrupt, input int keep);
    logic [7:0]  fb [0:63];
    logic [15:0] c;
    int          n;
    int          pos;
    n = plen + MIN_FRAME;
    fb[0] = HDR_BYTE;
    fb[1] = HDR_BYTE;
    fb[2] = 8'(n);
    fb[3] = ftype;
    fb[4] = seq;
    for (int i = 0; i < plen; i++) fb[5 + i] = 8'($urandom);
    c = CRC_INIT;
    for (int i = 0; i < n - 2; i++) begin
      c ^= {fb[i], 8'h00};
      for (int j = 0; j < 8; j++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    fb[n - 2] = c[15:8];
    fb[n - 1] = c[7:0];
    if (corrupt) begin
      pos = $urandom_range(n - 1, 3);
      fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(7));
    end
    if (keep == 0 || keep > n) keep = n;
    for (int i = 0; i < keep; i++) send_byte(fb[i]);
    frame_bytes_sent += keep;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    int r;
    int plen;
    logic [7:0] b;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // discards, wrong second header, lengths just out of range, two empty frames
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_BYTE);
    send_byte(8'h55);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'(MIN_FRAME - 1));
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(8'(MAX_FRAME + 1));
    send_frame(8'hFF, 8'h00, 0, 1'b0, 0);
    send_frame(8'h00, 8'hFF, 0, 1'b1, 0);

    // long receiver hold-off while full-size and short frames keep coming
    hold_go = ~hold_go;
    send_frame(8'($urandom), 8'($urandom), MAX_FRAME - MIN_FRAME, 1'b0, 0);
    send_frame(8'($urandom), 8'($urandom), 4, 1'b0, 0);
    send_frame(8'($urandom), 8'($urandom), 0, 1'b0, 0);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tbl[p];
      stall_pct = stall_tbl[p];
      target    = frame_bytes_sent + PHASE_BYTES;
      while (frame_bytes_sent < target) begin
        r = $urandom_range(99);
        plen = $urandom_range(99);
        plen = (plen < 5) ? MAX_FRAME - MIN_FRAME :
               (plen < 25) ? $urandom_range(24, 7) : $urandom_range(6, 0);
        if (r < 72) begin
          send_frame(8'($urandom), 8'($urandom), plen, $urandom_range(99) < 15, 0);
        end else if (r < 82) begin
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
        end else if (r < 92) begin
          send_byte(HDR_BYTE);
          b = 8'($urandom);
          if (b == HDR_BYTE) begin
            send_byte(HDR_BYTE);
            b = $urandom_range(1) ? 8'($urandom_range(MIN_FRAME - 1, 0)) :
                                    8'($urandom_range(255, MAX_FRAME + 1));
          end
          send_byte(b);
        end else begin
          send_frame(8'($urandom), 8'($urandom), plen, 1'b0, $urandom_range(8, 3));
        end
      end
      if (p == 1) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
